FILE: design/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  // Whole degrees below a full turn fit in this many bits
  localparam int HUE_INT_BITS = 9;
  // Whole degrees inside one sector fit in this many bits
  localparam int SECTOR_DEG_BITS = 6;
  localparam int DEG_PER_SECTOR = 60;
  localparam int FULL_DEG = 360;

  typedef logic [2:0] sector_t;

  localparam sector_t SECTOR_RED_YELLOW = 3'd0;
  localparam sector_t SECTOR_YELLOW_GREEN = 3'd1;
  localparam sector_t SECTOR_GREEN_CYAN = 3'd2;
  localparam sector_t SECTOR_CYAN_BLUE = 3'd3;
  localparam sector_t SECTOR_BLUE_MAGENTA = 3'd4;
  localparam sector_t SECTOR_MAGENTA_RED = 3'd5;

endpackage

FILE: design/hsv_to_rgb_converter_top.sv
// HSV to RGB pixel converter.
// Input channel: in_valid / in_stall carry one HSV item (hue, saturation, brightness).
// Hue is unsigned degrees with HUE_FRACTION_BITS fraction bits; a hue at or above 360
// degrees wraps once. Saturation and brightness are CHANNEL_BITS-bit fractions where
// all ones means 1.0.
// Output channel: out_valid / out_stall carry one RGB item (red, green, blue) per input
// item, each channel rounded once to the nearest code, halves up.
// Throughput: one item per clock. Every stage holds an item and a valid bit, so a new
// item enters each cycle while the pipeline moves.
// Eight register stages: hue wrap and products, sector, mirror and scale, X term,
// rounding offset, two stages of reciprocal multiplies for the constant divisions,
// and the output register.
// Stall: when out_stall is high a full output register holds; bubbles ahead of it still
// close up, and in_stall rises only once every stage holds an item.
// Reset: rst clears all valid bits; pipeline data is left as is.
module hsv_to_rgb_converter_top #(
  parameter int CHANNEL_BITS = 8,
  parameter int HUE_FRACTION_BITS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [8+HUE_FRACTION_BITS:0]        hue,
  input  logic [CHANNEL_BITS-1:0]             saturation,
  input  logic [CHANNEL_BITS-1:0]             brightness,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [CHANNEL_BITS-1:0]             red,
  output logic [CHANNEL_BITS-1:0]             green,
  output logic [CHANNEL_BITS-1:0]             blue
);

  import hsv2rgb_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int HF = HUE_FRACTION_BITS;
  localparam int HW = HUE_INT_BITS + HF;      // hue width
  localparam int FW = SECTOR_DEG_BITS + HF;   // offset inside a sector
  localparam int AW = 2 * CB;                 // channel products
  localparam int WAW = AW + FW;               // products scaled by a sector width
  localparam int NW = 2 * CB + 7 + HF;        // mid numerator
  localparam int LW = 2 * CB + 1;             // dividends of the division by CH_MAX
  localparam int NS = 8;                      // stages including the output register

  // Twice the denominator is CH_MAX * W_ODD << (HF + 3): drop the power of two by a
  // shift, then divide by W_ODD and by CH_MAX in turn. Nested floors stay exact.
  localparam int W_ODD = DEG_PER_SECTOR / 4;
  localparam int ZW = NW - HF - 3;            // mid numerator after the shift
  localparam int K_ODD = ZW + 4;              // W_ODD is below 16
  localparam int KM = LW + CB;
  localparam int RMW = 2 * CB + 2;
  localparam int PZW = 2 * ZW + 1;
  localparam int PMW = LW + RMW;

  localparam logic [CB-1:0] CH_MAX = {CB{1'b1}};
  localparam logic [HW-1:0] FULL_TURN = HW'(FULL_DEG) << HF;
  localparam logic [FW-1:0] SECTOR_W = FW'(DEG_PER_SECTOR) << HF;
  localparam logic [NW-1:0] DEN_HALF = NW'(CH_MAX) * NW'(SECTOR_W);
  localparam logic [ZW:0] R_ODD =
    (ZW+1)'(((64'd1 << K_ODD) + 64'(W_ODD) - 64'd1) / 64'(W_ODD));
  localparam logic [RMW-1:0] R_M =
    RMW'(((64'd1 << KM) + 64'(CH_MAX) - 64'd1) / 64'(CH_MAX));

  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  // Pipeline control: a stage loads when it is empty or its successor moves
  assign adv[NS-1] = !vld[NS-1] || !out_stall;
  for (genvar k = 0; k < NS - 1; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  assign in_stall = !adv[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: wrap hue, form S*V and V*(1-S)
  logic [HW-1:0] h1;
  logic [AW-1:0] sv1;
  logic [AW-1:0] a1;
  logic [CB-1:0] v1;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      h1 <= (hue >= FULL_TURN) ? hue - FULL_TURN : hue;
      sv1 <= AW'(saturation) * AW'(brightness);
      a1 <= AW'(CH_MAX - saturation) * AW'(brightness);
      v1 <= brightness;
    end
  end

  // Stage 2: find the sector and the offset inside it
  logic [HUE_INT_BITS-1:0] hdeg;
  sector_t sec_next;
  logic [HW-1:0] sec_base;
  sector_t sec2;
  logic [FW-1:0] f2;
  logic [AW-1:0] sv2;
  logic [AW-1:0] a2;
  logic [CB-1:0] v2;

  always_comb begin
    hdeg = h1[HW-1:HF];
    priority if (hdeg >= HUE_INT_BITS'(5 * DEG_PER_SECTOR)) begin
      sec_next = SECTOR_MAGENTA_RED;
    end else if (hdeg >= HUE_INT_BITS'(4 * DEG_PER_SECTOR)) begin
      sec_next = SECTOR_BLUE_MAGENTA;
    end else if (hdeg >= HUE_INT_BITS'(3 * DEG_PER_SECTOR)) begin
      sec_next = SECTOR_CYAN_BLUE;
    end else if (hdeg >= HUE_INT_BITS'(2 * DEG_PER_SECTOR)) begin
      sec_next = SECTOR_GREEN_CYAN;
    end else if (hdeg >= HUE_INT_BITS'(DEG_PER_SECTOR)) begin
      sec_next = SECTOR_YELLOW_GREEN;
    end else begin
      sec_next = SECTOR_RED_YELLOW;
    end
    sec_base = HW'(DEG_PER_SECTOR * int'(sec_next)) << HF;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sec2 <= sec_next;
      f2 <= FW'(h1 - sec_base);
      sv2 <= sv1;
      a2 <= a1;
      v2 <= v1;
    end
  end

  // Stage 3: mirror the offset in odd sectors, scale V*(1-S) by the sector width.
  // The min channel rounds as floor((2a + CH_MAX) / 2) / CH_MAX = (a + CH_MAX / 2) / CH_MAX.
  sector_t sec3;
  logic [FW-1:0] t3;
  logic [WAW-1:0] wa3;
  logic [AW-1:0] sv3;
  logic [LW-1:0] nlo3;
  logic [CB-1:0] v3;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sec3 <= sec2;
      t3 <= sec2[0] ? SECTOR_W - f2 : f2;
      wa3 <= WAW'(a2) * WAW'(SECTOR_W);
      sv3 <= sv2;
      nlo3 <= LW'(a2) + LW'(CH_MAX >> 1);
      v3 <= v2;
    end
  end

  // Stage 4: X term before scaling
  sector_t sec4;
  logic [WAW-1:0] prod4;
  logic [WAW-1:0] wa4;
  logic [LW-1:0] nlo4;
  logic [CB-1:0] v4;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      sec4 <= sec3;
      prod4 <= WAW'(sv3) * WAW'(t3);
      wa4 <= wa3;
      nlo4 <= nlo3;
      v4 <= v3;
    end
  end

  // Stage 5: mid numerator with the half-unit rounding offset, power of two dropped
  sector_t sec5;
  logic [ZW-1:0] nmid5;
  logic [LW-1:0] nlo5;
  logic [CB-1:0] v5;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      sec5 <= sec4;
      nmid5 <= ZW'((((NW'(wa4) + NW'(prod4)) << 1) + DEN_HALF) >> (HF + 3));
      nlo5 <= nlo4;
      v5 <= v4;
    end
  end

  // Stage 6: divide the mid numerator by W_ODD, the min numerator by CH_MAX
  sector_t sec6;
  logic [PZW-1:0] pz6;
  logic [PMW-1:0] pl6;
  logic [CB-1:0] v6;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      sec6 <= sec5;
      pz6 <= PZW'(nmid5) * PZW'(R_ODD);
      pl6 <= PMW'(nlo5) * PMW'(R_M);
      v6 <= v5;
    end
  end

  // Stage 7: divide the mid quotient by CH_MAX, take the min channel
  sector_t sec7;
  logic [PMW-1:0] pm7;
  logic [CB-1:0] lo7;
  logic [CB-1:0] v7;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      sec7 <= sec6;
      pm7 <= PMW'(pz6[K_ODD +: LW]) * PMW'(R_M);
      lo7 <= pl6[KM +: CB];
      v7 <= v6;
    end
  end

  // Output register: place max, mid and min by sector
  logic [CB-1:0] hi;
  logic [CB-1:0] md;
  logic [CB-1:0] lo;

  assign hi = v7;
  assign md = pm7[KM +: CB];
  assign lo = lo7;

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      unique case (sec7)
        SECTOR_RED_YELLOW: begin
          red <= hi;
          green <= md;
          blue <= lo;
        end
        SECTOR_YELLOW_GREEN: begin
          red <= md;
          green <= hi;
          blue <= lo;
        end
        SECTOR_GREEN_CYAN: begin
          red <= lo;
          green <= hi;
          blue <= md;
        end
        SECTOR_CYAN_BLUE: begin
          red <= lo;
          green <= md;
          blue <= hi;
        end
        SECTOR_BLUE_MAGENTA: begin
          red <= md;
          green <= lo;
          blue <= hi;
        end
        default: begin
          red <= hi;
          green <= lo;
          blue <= md;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb_hsv_to_rgb_converter_top.sv
module tb_hsv_to_rgb_converter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam int CH_BITS = 8;
  localparam int HF_BITS = 4;
  localparam int HUE_W = HUE_INT_BITS + HF_BITS;
  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 6;
  localparam int MAX_GAP = 6;
  localparam int LONG_HOLD = 80;
  localparam int DRAIN_CYCLES = 3 * (CH_BITS + 5);
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BLOCKS = 12;
  localparam int BLOCK_ITEMS = 100;
  localparam int NUM_CORNER = 23;

  // Hue codes: one sector, one full turn, and the largest code the port carries
  localparam longint unsigned SECTOR_CODES = longint'(DEG_PER_SECTOR) << HF_BITS;
  localparam longint unsigned FULL_CODES = longint'(FULL_DEG) << HF_BITS;
  localparam longint unsigned CH_FULL = (longint'(1) << CH_BITS) - 1;
  localparam int HUE_TOP = (1 << HUE_W) - 1;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } rgb_t;

  // One row of the corner-case table; typed rows carry their expected pixel
  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [CH_BITS-1:0] sat;
    logic [CH_BITS-1:0] val;
    logic               typed;
    rgb_t               want;
  } pixel_row_t;

  localparam rgb_t NO_RGB = '0;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [HUE_W-1:0]   hue = '0;
  logic [CH_BITS-1:0] saturation = '0;
  logic [CH_BITS-1:0] brightness = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CH_BITS-1:0] red;
  logic [CH_BITS-1:0] green;
  logic [CH_BITS-1:0] blue;

  // Expected pixels, oldest first
  rgb_t pixel_q[$];

  int error_count = 0;
  int cycle_count = 0;
  int pixel_count = 0;

  // Idling knobs, written by the stimulus process and read by the sender and the receiver
  int tx_gap_max = 0;
  int rx_stall_max = 0;
  int hold_req = 0;

  // Receiver state, owned by the posedge block of the receiver
  int stall_left = 0;
  int hold_left = 0;
  int hold_seen = 0;

  // Corner cases: black, white, gray, the six primaries and secondaries at full
  // saturation, sector boundaries, the wrap past 360 degrees, and field extremes
  pixel_row_t corner_rows [NUM_CORNER] = '{
    '{13'd0,    8'd0,   8'd0,   1'b1, {8'd0,   8'd0,   8'd0}},
    '{13'd0,    8'd0,   8'd255, 1'b1, {8'd255, 8'd255, 8'd255}},
    '{13'd0,    8'd255, 8'd255, 1'b1, {8'd255, 8'd0,   8'd0}},
    '{13'd960,  8'd255, 8'd255, 1'b1, {8'd255, 8'd255, 8'd0}},
    '{13'd1920, 8'd255, 8'd255, 1'b1, {8'd0,   8'd255, 8'd0}},
    '{13'd2880, 8'd255, 8'd255, 1'b1, {8'd0,   8'd255, 8'd255}},
    '{13'd3840, 8'd255, 8'd255, 1'b1, {8'd0,   8'd0,   8'd255}},
    '{13'd4800, 8'd255, 8'd255, 1'b1, {8'd255, 8'd0,   8'd255}},
    '{13'd5760, 8'd255, 8'd255, 1'b1, {8'd255, 8'd0,   8'd0}},
    '{13'd6720, 8'd255, 8'd255, 1'b1, {8'd255, 8'd255, 8'd0}},
    '{13'd7000, 8'd255, 8'd0,   1'b1, {8'd0,   8'd0,   8'd0}},
    '{13'd3000, 8'd0,   8'd128, 1'b1, {8'd128, 8'd128, 8'd128}},
    '{13'd5759, 8'd255, 8'd255, 1'b0, NO_RGB},
    '{13'd8191, 8'd255, 8'd255, 1'b0, NO_RGB},
    '{13'd480,  8'd255, 8'd255, 1'b0, NO_RGB},
    '{13'd1,    8'd255, 8'd255, 1'b0, NO_RGB},
    '{13'd959,  8'd255, 8'd255, 1'b0, NO_RGB},
    '{13'd2000, 8'd128, 8'd200, 1'b0, NO_RGB},
    '{13'd4000, 8'd1,   8'd1,   1'b0, NO_RGB},
    '{13'd1000, 8'd254, 8'd255, 1'b0, NO_RGB},
    '{13'd5000, 8'd170, 8'd85,  1'b0, NO_RGB},
    '{13'd4095, 8'd85,  8'd170, 1'b0, NO_RGB},
    '{13'd4096, 8'd170, 8'd85,  1'b0, NO_RGB}
  };

  hsv_to_rgb_converter_top #(
    .CHANNEL_BITS(CH_BITS),
    .HUE_FRACTION_BITS(HF_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .hue(hue),
    .saturation(saturation),
    .brightness(brightness),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red(red),
    .green(green),
    .blue(blue)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Exact conversion: work in units of 1/(M*W) and round once, halves up.
  // The brightest channel is V itself, the darkest is m = V - C, and the
  // middle one is m + X, where X grows with the offset in even sectors and
  // shrinks with it in odd ones.
  function automatic rgb_t hsv_to_rgb(input logic [HUE_W-1:0] h_in,
                                      input logic [CH_BITS-1:0] s_in,
                                      input logic [CH_BITS-1:0] v_in);
    longint unsigned h, s, v, f, t, den, sv, min_num, mid_num, lo, md, hi;
    sector_t sec;
    rgb_t px;
    h = longint'(h_in) % FULL_CODES;
    s = longint'(s_in);
    v = longint'(v_in);
    sec = sector_t'(h / SECTOR_CODES);
    f = h % SECTOR_CODES;
    t = sec[0] ? (SECTOR_CODES - f) : f;
    den = CH_FULL * SECTOR_CODES;
    sv = s * v;
    min_num = v * den - sv * SECTOR_CODES;
    mid_num = min_num + sv * t;
    hi = v;
    lo = (2 * min_num + den) / (2 * den);
    md = (2 * mid_num + den) / (2 * den);
    case (sec)
      SECTOR_RED_YELLOW: begin
        px = {hi[CH_BITS-1:0], md[CH_BITS-1:0], lo[CH_BITS-1:0]};
      end
      SECTOR_YELLOW_GREEN: begin
        px = {md[CH_BITS-1:0], hi[CH_BITS-1:0], lo[CH_BITS-1:0]};
      end
      SECTOR_GREEN_CYAN: begin
        px = {lo[CH_BITS-1:0], hi[CH_BITS-1:0], md[CH_BITS-1:0]};
      end
      SECTOR_CYAN_BLUE: begin
        px = {lo[CH_BITS-1:0], md[CH_BITS-1:0], hi[CH_BITS-1:0]};
      end
      SECTOR_BLUE_MAGENTA: begin
        px = {md[CH_BITS-1:0], lo[CH_BITS-1:0], hi[CH_BITS-1:0]};
      end
      default: begin
        px = {hi[CH_BITS-1:0], lo[CH_BITS-1:0], md[CH_BITS-1:0]};
      end
    endcase
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Offer one item after a random gap; hold the payload until the block takes
  // it, then queue the expected pixel. Called right after a falling edge.
  task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [CH_BITS-1:0] s,
                            input logic [CH_BITS-1:0] v, input rgb_t want);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    hue = h;
    saturation = s;
    brightness = v;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pixel_q.push_back(want);
    @(negedge clk);
  endtask

  // Random pixel: mostly in-range hue, some hues right on sector boundaries,
  // some past a full turn; saturation and brightness lean on their extremes now
  // and then.
  function automatic logic [CH_BITS-1:0] pick_channel();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return CH_BITS'(1);
        2: return CH_BITS'(CH_FULL - 1);
        default: return CH_BITS'(CH_FULL);
      endcase
    end
    return CH_BITS'($urandom_range(0, int'(CH_FULL)));
  endfunction

  function automatic logic [HUE_W-1:0] pick_hue();
    int pick;
    int bh;
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      return HUE_W'($urandom_range(0, int'(FULL_CODES) - 1));
    end else if (pick < 17) begin
      bh = $urandom_range(0, 5) * int'(SECTOR_CODES) + $urandom_range(0, 2) - 1;
      if (bh < 0) bh = int'(FULL_CODES) - 1;
      return HUE_W'(bh);
    end
    return HUE_W'($urandom_range(int'(FULL_CODES), HUE_TOP));
  endfunction

  // Stimulus: reset, the corner table, then random blocks with varying idling
  initial begin
    pixel_row_t row;
    logic [HUE_W-1:0] h;
    logic [CH_BITS-1:0] s;
    logic [CH_BITS-1:0] v;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the corner table with moderate idling on both sides
    tx_gap_max = 2;
    rx_stall_max = 2;
    for (int i = 0; i < NUM_CORNER; i++) begin
      row = corner_rows[i];
      send_pixel(row.hue, row.sat, row.val,
                 row.typed ? row.want : hsv_to_rgb(row.hue, row.sat, row.val));
    end

    // Random blocks; rotate idling so bubbles and stalls land on every
    // pipeline phase, with stretches of none at all
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      case (b % 4)
        0: begin tx_gap_max = 0; rx_stall_max = 0; end
        1: begin tx_gap_max = MAX_GAP; rx_stall_max = 0; end
        2: begin tx_gap_max = 0; rx_stall_max = MAX_GAP; end
        default: begin tx_gap_max = MAX_GAP; rx_stall_max = MAX_GAP; end
      endcase
      // Once, hold the receiver off for a long stretch while items keep coming,
      // so the pipeline fills and stalls its input
      if (b == 5) begin
        tx_gap_max = 0;
        rx_stall_max = 0;
        hold_req++;
      end
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        h = pick_hue();
        s = pick_channel();
        v = pick_channel();
        send_pixel(h, s, v, hsv_to_rgb(h, s, v));
      end
    end

    // Drop valid, let the receiver run freely, and wait out the pipeline
    in_valid = 1'b0;
    rx_stall_max = 0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("hsv_to_rgb_converter_top test passed");
    end else begin
      $display("hsv_to_rgb_converter_top test failed");
    end
    $finish;
  end

  // Receiver: drive stall at the falling edge from the counters below
  always @(negedge clk) begin
    out_stall = (hold_left > 0) || (stall_left > 0);
  end

  // Receiver: take results at the rising edge, check them, draw the next stall
  always @(posedge clk) begin
    rgb_t want;
    rgb_t got;
    if (!rst && $isunknown(out_valid)) begin
      report_mismatch("out_valid is unknown");
    end
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      got = {red, green, blue};
      if (pixel_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel r=%0d g=%0d b=%0d",
                                  got.red, got.green, got.blue));
      end else begin
        want = pixel_q.pop_front();
        if (got.red !== want.red) begin
          report_mismatch($sformatf("pixel %0d red %0d, want %0d",
                                    pixel_count, got.red, want.red));
        end
        if (got.green !== want.green) begin
          report_mismatch($sformatf("pixel %0d green %0d, want %0d",
                                    pixel_count, got.green, want.green));
        end
        if (got.blue !== want.blue) begin
          report_mismatch($sformatf("pixel %0d blue %0d, want %0d",
                                    pixel_count, got.blue, want.blue));
        end
      end
      pixel_count++;
      stall_left = $urandom_range(rx_stall_max, 0);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // Watchdog: end the run if it takes far longer than the slowest correct run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hsv_to_rgb_converter_top test failed");
      $finish;
    end
  end

endmodule
